// ===== hdl/cuwm_pkg.sv =====
// cuwm_pkg: shared types, codes and constants of the card uid whitelist match block
// no dependencies; used by the entry cell and the top level

package cuwm_pkg;

	localparam int MAX_ENTRIES_DEF = 32;
	localparam logic [3:0] MIN_UID_BYTES = 4'd4;
	localparam logic [3:0] MAX_UID_BYTES = 4'd10;
	localparam logic [15:0] COOLDOWN_RESET = 16'd1000;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_CHECK = 2'd1,
		OP_TICK  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_ADDED   = 3'd0,
		ST_BADLEN  = 3'd1,
		ST_DUP     = 3'd2,
		ST_FULL    = 3'd3,
		ST_GRANTED = 3'd4,
		ST_DENIED  = 3'd5,
		ST_IGNORED = 3'd6,
		ST_TICK    = 3'd7
	} status_t;

	typedef struct packed {
		logic [3:0]  len;
		logic [63:0] low;
		logic [15:0] high;
	} entry_t;

	// keep bytes 0..len-1 of the low word, byte 0 is the top byte
	function automatic logic [63:0] low_mask(input logic [3:0] len);
		logic [6:0] sh;
		logic [63:0] m;
		sh = 7'd64 - {1'b0, len[2:0], 3'b000};
		if (len >= 4'd8) begin
			m = '1;
		end else if (len == 4'd0) begin
			m = '0;
		end else begin
			m = {64{1'b1}} << sh;
		end
		return m;
	endfunction

	function automatic logic [15:0] high_mask(input logic [3:0] len);
		logic [15:0] m;
		if (len >= 4'd10) begin
			m = 16'hFFFF;
		end else if (len == 4'd9) begin
			m = 16'hFF00;
		end else begin
			m = 16'h0000;
		end
		return m;
	endfunction

endpackage

// ===== hdl/cuwm_req_if.sv =====
// cuwm_req_if: request channel, valid/ready handshake plus the item fields
// depends on nothing

interface cuwm_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [3:0]  uid_length;
	logic [63:0] uid_low;
	logic [15:0] uid_high;
	logic        lockout;
	logic [31:0] now_ms;

	modport source (
		output valid, opcode, uid_length, uid_low, uid_high, lockout, now_ms,
		input  ready
	);
	modport sink (
		input  valid, opcode, uid_length, uid_low, uid_high, lockout, now_ms,
		output ready
	);
endinterface

// ===== hdl/cuwm_rsp_if.sv =====
// cuwm_rsp_if: result channel, valid/ready handshake plus the result fields
// depends on nothing

interface cuwm_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [5:0] card_count;
	logic       feedback_active;

	modport source (
		output valid, status, card_count, feedback_active,
		input  ready
	);
	modport sink (
		input  valid, status, card_count, feedback_active,
		output ready
	);
endinterface

// ===== hdl/cuwm_cell.sv =====
// cuwm_cell: one whitelist entry; shifts to its neighbor on an append and
// compares itself against the broadcast key. depends on cuwm_pkg

module cuwm_cell (
	input  logic              clk,
	input  logic              shift_en,
	input  logic              valid,
	input  cuwm_pkg::entry_t  shift_in,
	input  cuwm_pkg::entry_t  key,
	output cuwm_pkg::entry_t  shift_out,
	output logic              hit
);

	cuwm_pkg::entry_t entry_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			entry_q <= shift_in;
		end
	end

	assign shift_out = entry_q;
	assign hit = valid && (entry_q == key);

endmodule

// ===== hdl/card_uid_whitelist_match_top.sv =====
// card_uid_whitelist_match_top: whitelist of card uids held in a row of entry cells,
// with add / check / tick handling and the error feedback deadline
// depends on cuwm_pkg, cuwm_req_if, cuwm_rsp_if, cuwm_cell
//
//  channel  dir  handshake          payload
//  req      in   valid / ready      opcode, uid_length, uid_low, uid_high, lockout, now_ms
//  rsp      out  valid / ready      status, card_count, feedback_active
//  cfg      in   cfg_we             cfg_wdata (error_cooldown_ms)
//
// an item is captured and its key masked in S_IDLE, then in S_RUN every cell
// compares in parallel and the table, count and deadline update
// the result register holds the outcome; a stalled rsp holds the item in
// S_RUN and req.ready stays low until the result register frees up
// reset clears count and deadline and loads the default cooldown; entries need
// no clearing, only cells below the count take part in a compare

module card_uid_whitelist_match_top #(
	parameter int MAX_ENTRIES = cuwm_pkg::MAX_ENTRIES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_wdata,
	cuwm_req_if.sink            req,
	cuwm_rsp_if.source          rsp
);

	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

	typedef enum logic {
		S_IDLE,
		S_RUN
	} state_t;

	state_t                 state_q;
	logic [CNT_W-1:0]       count_q;
	logic [31:0]            deadline_q;
	logic [15:0]            cooldown_q;
	logic                   rsp_valid_q;
	cuwm_pkg::status_t      status_q;

	// captured item
	cuwm_pkg::entry_t       key_q;
	cuwm_pkg::op_t          op_q;
	logic                   lock_q;
	logic [31:0]            now_q;

	cuwm_pkg::entry_t       chain [MAX_ENTRIES+1];
	logic [MAX_ENTRIES-1:0] cell_valid;
	logic [MAX_ENTRIES-1:0] cell_hit;

	logic                   hit;
	logic                   full;
	logic                   slot_free;
	logic                   do_append;
	logic [31:0]            since_dl;
	logic [CNT_W-1:0]       count_nxt;
	logic [31:0]            deadline_nxt;
	cuwm_pkg::status_t      status_nxt;

	assign req.ready = (state_q == S_IDLE);

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			key_q.len  <= req.uid_length;
			key_q.low  <= req.uid_low & cuwm_pkg::low_mask(req.uid_length);
			key_q.high <= req.uid_high & cuwm_pkg::high_mask(req.uid_length);
			op_q       <= cuwm_pkg::op_t'(req.opcode);
			lock_q     <= req.lockout;
			now_q      <= req.now_ms;
		end
	end

	// new entries enter at cell 0 and older ones move one cell along
	assign chain[0] = key_q;

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		assign cell_valid[i] = (CNT_W'(i) < count_q);
		cuwm_cell u_cell (
			.clk      (clk),
			.shift_en (do_append),
			.valid    (cell_valid[i]),
			.shift_in (chain[i]),
			.key      (key_q),
			.shift_out(chain[i+1]),
			.hit      (cell_hit[i])
		);
	end

	assign hit       = |cell_hit;
	assign full      = (count_q == CNT_W'(MAX_ENTRIES));
	assign slot_free = !rsp_valid_q || rsp.ready;
	assign since_dl  = now_q - deadline_q;

	always_comb begin
		count_nxt    = count_q;
		deadline_nxt = deadline_q;
		do_append    = 1'b0;
		status_nxt   = cuwm_pkg::ST_IGNORED;
		case (op_q)
			cuwm_pkg::OP_ADD: begin
				if (key_q.len < cuwm_pkg::MIN_UID_BYTES ||
					key_q.len > cuwm_pkg::MAX_UID_BYTES) begin
					status_nxt = cuwm_pkg::ST_BADLEN;
				end else if (hit) begin
					status_nxt = cuwm_pkg::ST_DUP;
				end else if (full) begin
					status_nxt = cuwm_pkg::ST_FULL;
				end else begin
					status_nxt = cuwm_pkg::ST_ADDED;
					count_nxt  = count_q + CNT_W'(1);
					do_append  = (state_q == S_RUN) && slot_free;
				end
			end
			cuwm_pkg::OP_CHECK: begin
				if (lock_q || key_q.len > cuwm_pkg::MAX_UID_BYTES) begin
					status_nxt = cuwm_pkg::ST_IGNORED;
				end else if (hit) begin
					status_nxt = cuwm_pkg::ST_GRANTED;
				end else begin
					status_nxt   = cuwm_pkg::ST_DENIED;
					deadline_nxt = now_q + {16'd0, cooldown_q};
				end
			end
			cuwm_pkg::OP_TICK: begin
				status_nxt = cuwm_pkg::ST_TICK;
				// wrap-safe: deadline passed when now - deadline is not negative
				if (deadline_q != 32'd0 && !since_dl[31]) begin
					deadline_nxt = 32'd0;
				end
			end
			default: begin
				status_nxt = cuwm_pkg::ST_IGNORED;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			deadline_q  <= 32'd0;
			cooldown_q  <= cuwm_pkg::COOLDOWN_RESET;
			rsp_valid_q <= 1'b0;
			status_q    <= cuwm_pkg::ST_ADDED;
		end else begin
			if (cfg_we) begin
				cooldown_q <= cfg_wdata;
			end
			unique case (state_q)
				S_IDLE: begin
					if (rsp.ready) begin
						rsp_valid_q <= 1'b0;
					end
					if (req.valid) begin
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					// a pending result leaves as the new one is loaded
					if (slot_free) begin
						count_q     <= count_nxt;
						deadline_q  <= deadline_nxt;
						status_q    <= status_nxt;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.status          = status_q;
	assign rsp.card_count      = 6'(count_q);
	assign rsp.feedback_active = (deadline_q != 32'd0);

`ifndef NO_ASSERTIONS
	a_result_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_RUN))
		else $error("result appeared without an item in progress");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ENTRIES))
		else $error("card count above table size");

	a_count_on_add: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |->
			(count_q == $past(count_q) + CNT_W'(1)) && rsp_valid_q &&
			(status_q == cuwm_pkg::ST_ADDED))
		else $error("card count changed other than by an append");

	a_arm_on_deny: assert property (@(posedge clk) disable iff (!arst_n)
		(deadline_q != 32'd0) && ($past(deadline_q) == 32'd0) |->
			rsp_valid_q && (status_q == cuwm_pkg::ST_DENIED))
		else $error("feedback deadline armed without a denied check");
`endif

endmodule
